FILE: rtl/core/dle_framed_packet_receiver_top_macros.svh
// ----------------------------------------------------------------------------
// DLE frame receiver assertion macros
// Concurrent check wrappers, removed when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DLE_FRAMED_PACKET_RECEIVER_TOP_MACROS_SVH
`define DLE_FRAMED_PACKET_RECEIVER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define DFPR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dfpr: same-cycle check failed");

`define DFPR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dfpr: next-cycle check failed");

`else

`define DFPR_ASSERT_IMP(label, clk, rst, ante, cons)

`define DFPR_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/dfpr_pkg.sv
// ----------------------------------------------------------------------------
// DLE frame receiver package
// Shared types, register indexes and constants.
// ----------------------------------------------------------------------------
package dfpr_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GEN_POLY       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CODE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_CODE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NAK_CODE       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT   = 3'd6;

  localparam logic [7:0] MAX_FRAME_BYTES = 8'd128;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_ACK         = 3'd1,
    EV_NAK         = 3'd2,
    EV_CHECK_ERROR = 3'd3,
    EV_FRAME_OK    = 3'd4,
    EV_TIMEOUT     = 3'd5
  } frame_event_t;

  typedef struct packed {
    logic        checksum_mode;
    logic [15:0] gen_poly;
    logic [7:0]  escape_code;
    logic [7:0]  end_code;
    logic [7:0]  ack_code;
    logic [7:0]  nak_code;
    logic [15:0] idle_timeout;
  } cfg_t;

  typedef struct packed {
    logic         byte_stored;
    logic [6:0]   byte_index;
    logic [7:0]   byte_value;
    frame_event_t frame_event;
    logic [7:0]   command_byte;
    logic [7:0]   nak_error;
    logic [7:0]   length_byte;
    logic [15:0]  computed_check;
    logic [15:0]  received_check;
  } res_t;

endpackage

FILE: rtl/core/dfpr_cfg.sv
// ----------------------------------------------------------------------------
// DLE frame receiver configuration registers
// Holds the seven control registers written over the config channel.
// ----------------------------------------------------------------------------
module dfpr_cfg import dfpr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [15:0]          wr_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.checksum_mode  <= 1'b0;
      cfg.gen_poly       <= 16'h1021;
      cfg.escape_code    <= 8'h10;
      cfg.end_code       <= 8'h1F;
      cfg.ack_code       <= 8'h16;
      cfg.nak_code       <= 8'h19;
      cfg.idle_timeout   <= 16'd10;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_CHECKSUM_MODE:  cfg.checksum_mode  <= wr_data[0];
        CFG_GEN_POLY:       cfg.gen_poly       <= wr_data;
        CFG_ESCAPE_CODE:    cfg.escape_code    <= wr_data[7:0];
        CFG_END_CODE:       cfg.end_code       <= wr_data[7:0];
        CFG_ACK_CODE:       cfg.ack_code       <= wr_data[7:0];
        CFG_NAK_CODE:       cfg.nak_code       <= wr_data[7:0];
        CFG_IDLE_TIMEOUT:   cfg.idle_timeout   <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/dfpr_check.sv
// ----------------------------------------------------------------------------
// DLE frame receiver check update
// One-byte update of the additive sum or the MSB-first CRC-16.
// ----------------------------------------------------------------------------
module dfpr_check import dfpr_pkg::*; (
  input  logic        mode,
  input  logic [15:0] poly,
  input  logic [15:0] acc,
  input  logic [7:0]  data,
  output logic [15:0] acc_next
);

  logic [15:0] crc;
  logic [15:0] feed;

  always_comb begin
    crc  = 16'h0000;
    feed = {acc[15:8] ^ data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (crc[15] ^ feed[15]) begin
        crc = {crc[14:0], 1'b0} ^ poly;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
      feed = {feed[14:0], 1'b0};
    end
    if (mode) begin
      acc_next = {acc[7:0], 8'h00} ^ crc;
    end else begin
      acc_next = acc + {8'h00, data};
    end
  end

endmodule

FILE: rtl/core/dfpr_frame.sv
// ----------------------------------------------------------------------------
// DLE frame receiver frame tracker
// Frame state registers and the per-transaction next-state and result logic.
// ----------------------------------------------------------------------------
module dfpr_frame import dfpr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       step,
  input  logic       func,
  input  logic [7:0] rx_byte,
  output res_t       res
);

  typedef struct packed {
    logic        in_frame;
    logic        escape_seen;
    logic        end_seen;
    logic        nak_pending;
    logic [7:0]  stored_count;
    logic [1:0]  check_bytes_seen;
    logic [15:0] running_check;
    logic [7:0]  held_command;
    logic [7:0]  held_length;
    logic [7:0]  first_check_byte;
    logic [15:0] idle_counter;
  } st_t;

  st_t         st;
  st_t         st_next;
  logic        buf_full;
  logic [15:0] chk_acc;
  logic [15:0] chk_next;

  assign buf_full = (st.stored_count >= MAX_FRAME_BYTES);
  assign chk_acc  = buf_full ? 16'h0000 : st.running_check;

  dfpr_check u_check (
    .mode     (cfg.checksum_mode),
    .poly     (cfg.gen_poly),
    .acc      (chk_acc),
    .data     (rx_byte),
    .acc_next (chk_next)
  );

  always_comb begin
    logic        is_esc;
    logic        store;
    logic        sum;
    logic        complete;
    logic        is_ack;
    logic        stuffed;
    logic [15:0] recv;
    logic [7:0]  nak_err;
    st_t         cur;

    is_esc   = (rx_byte == cfg.escape_code);
    store    = 1'b0;
    sum      = 1'b0;
    complete = 1'b0;
    is_ack   = 1'b0;
    stuffed  = 1'b0;
    recv     = 16'h0000;
    nak_err  = 8'h00;
    res      = '0;
    cur      = st;
    st_next  = st;

    if (func) begin
      if (st.idle_counter != 16'd0) begin
        st_next.idle_counter = st.idle_counter - 16'd1;
        if (st.idle_counter == 16'd1) begin
          if (st.in_frame) begin
            res.frame_event    = EV_TIMEOUT;
            res.command_byte   = st.held_command;
            res.length_byte    = st.held_length;
            res.computed_check = st.running_check;
          end
          st_next = '0;
        end
      end
    end else begin
      if (buf_full) begin
        cur = '0;
        cur.idle_counter = st.idle_counter;
      end
      st_next = cur;

      if (is_esc && !cur.end_seen) begin
        if (!cur.in_frame) begin
          st_next.in_frame     = 1'b1;
          st_next.stored_count = 8'd0;
          st_next.escape_seen  = 1'b1;
        end else if (cur.escape_seen) begin
          stuffed = 1'b1;
        end else begin
          st_next.escape_seen = 1'b1;
        end
        store = 1'b1;
        sum   = 1'b1;
      end else if (rx_byte == cfg.end_code && cur.escape_seen && !cur.end_seen) begin
        store                    = 1'b1;
        sum                      = 1'b1;
        st_next.end_seen         = 1'b1;
        st_next.check_bytes_seen = 2'd0;
      end else if (cur.end_seen) begin
        store = 1'b1;
        if (cur.check_bytes_seen == 2'd0) begin
          st_next.first_check_byte = rx_byte;
          st_next.check_bytes_seen = 2'd1;
        end else begin
          recv                     = {cur.first_check_byte, rx_byte};
          st_next.check_bytes_seen = 2'd2;
          complete                 = 1'b1;
        end
      end else if (cur.nak_pending) begin
        nak_err  = rx_byte;
        store    = 1'b1;
        complete = 1'b1;
      end else if (cur.in_frame) begin
        if (cur.escape_seen && cur.stored_count == 8'd1) begin
          st_next.held_command = rx_byte;
          if (rx_byte == cfg.nak_code) begin
            st_next.nak_pending = 1'b1;
          end
          if (rx_byte == cfg.ack_code) begin
            is_ack   = 1'b1;
            complete = 1'b1;
          end
        end
        store = 1'b1;
        sum   = 1'b1;
      end

      if (!is_esc || stuffed) begin
        st_next.escape_seen = 1'b0;
      end

      if (store) begin
        res.byte_stored = 1'b1;
        res.byte_index  = st_next.stored_count[6:0];
        res.byte_value  = rx_byte;
        if (st_next.stored_count == 8'd2) begin
          st_next.held_length = rx_byte;
        end
        st_next.stored_count = st_next.stored_count + 8'd1;
      end

      if (sum) begin
        st_next.running_check = chk_next;
      end

      st_next.idle_counter = cfg.idle_timeout;

      if (complete) begin
        priority if (is_ack) begin
          res.frame_event = EV_ACK;
        end else if (st_next.nak_pending) begin
          res.frame_event = EV_NAK;
        end else if (recv != st_next.running_check) begin
          res.frame_event = EV_CHECK_ERROR;
        end else begin
          res.frame_event = EV_FRAME_OK;
        end
        res.command_byte     = st_next.held_command;
        res.nak_error        = nak_err;
        res.length_byte      = st_next.held_length;
        res.computed_check   = st_next.running_check;
        res.received_check   = recv;
        st_next              = '0;
        st_next.idle_counter = cfg.idle_timeout;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step) begin
      st <= st_next;
    end
  end

endmodule

FILE: rtl/core/dle_framed_packet_receiver_top.sv
// ----------------------------------------------------------------------------
// DLE framed packet receiver
// Byte-stuffed frame decoder with additive or CRC-16 check and idle timeout.
// ----------------------------------------------------------------------------
// Accepts one transaction per clock while in_stall is low, either a received
// byte or a timer tick, and returns exactly one result transaction for each:
// an input register feeds the frame tracker, whose combinational update
// (including the eight unrolled CRC steps) loads the result register.
// Configuration writes are always taken (cfg_ready is tied high) and must
// only be issued while the block is idle. A result may sit stalled at the
// output while the next transaction is already held in the input register.
module dle_framed_packet_receiver_top import dfpr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 func,
  input  logic [7:0]           rx_byte,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 byte_stored,
  output logic [6:0]           byte_index,
  output logic [7:0]           byte_value,
  output logic [2:0]           frame_event,
  output logic [7:0]           command_byte,
  output logic [7:0]           nak_error,
  output logic [7:0]           length_byte,
  output logic [15:0]          computed_check,
  output logic [15:0]          received_check,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  `include "dle_framed_packet_receiver_top_macros.svh"

  cfg_t       cfg;
  res_t       res;
  res_t       out_q;
  logic       in_q_valid;
  logic       in_q_func;
  logic [7:0] in_q_byte;
  logic       step;

  assign cfg_ready = 1'b1;
  assign step      = in_q_valid && (!out_valid || !out_stall);
  assign in_stall  = in_q_valid && !step;

  dfpr_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  dfpr_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (step),
    .func    (in_q_func),
    .rx_byte (in_q_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q_func <= func;
      in_q_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign byte_stored    = out_q.byte_stored;
  assign byte_index     = out_q.byte_index;
  assign byte_value     = out_q.byte_value;
  assign frame_event    = out_q.frame_event;
  assign command_byte   = out_q.command_byte;
  assign nak_error      = out_q.nak_error;
  assign length_byte    = out_q.length_byte;
  assign computed_check = out_q.computed_check;
  assign received_check = out_q.received_check;

  `DFPR_ASSERT_IMP(a_no_store_zero, clk, rst, out_valid && !byte_stored, byte_index == 7'd0 && byte_value == 8'd0)
  `DFPR_ASSERT_IMP(a_no_event_zero, clk, rst, out_valid && out_q.frame_event == EV_NONE, command_byte == 8'd0 && computed_check == 16'd0 && received_check == 16'd0)
  `DFPR_ASSERT_IMP(a_timeout_no_store, clk, rst, out_valid && out_q.frame_event == EV_TIMEOUT, !byte_stored)
  `DFPR_ASSERT_NXT(a_step_valid, clk, rst, step, out_valid)

endmodule

FILE: tb/dle_framed_packet_receiver_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DLE framed packet receiver testbench
// Runs a directed byte/tick table, then random framed traffic under several
// register settings and flow patterns. Every result transaction is checked
// field by field against an in-bench frame decoder or a typed-in row value.
// ----------------------------------------------------------------------------
module dle_framed_packet_receiver_top_test;
  import dfpr_pkg::*;

  typedef enum int {FLOW_FREE, FLOW_SRC_GAPS, FLOW_SINK_STALLS, FLOW_BOTH} flow_t;

  typedef struct packed {
    logic       f;
    logic [7:0] b;
    logic       typed;
    res_t       exp;
  } stim_row_t;

  localparam int NUM_ROWS = 29;
  localparam int PHASE_ITEMS = 105;

  localparam cfg_t DIRECTED_CFG = '{1'b0, 16'h1021, 8'h10, 8'h1F, 8'h16, 8'h19, 16'd2};

  localparam cfg_t PHASE_CFG [6] = '{
    '{1'b0, 16'h1021, 8'h10, 8'h1F, 8'h16, 8'h19, 16'd10},
    '{1'b1, 16'h1021, 8'h10, 8'h1F, 8'h16, 8'h19, 16'd3},
    '{1'b1, 16'hFFFF, 8'hFF, 8'h00, 8'h01, 8'h02, 16'hFFFF},
    '{1'b1, 16'h0000, 8'h00, 8'hFF, 8'hFE, 8'h80, 16'd1},
    '{1'b0, 16'h8005, 8'h55, 8'h55, 8'h33, 8'h33, 16'd0},
    '{1'b1, 16'h8005, 8'h7D, 8'h7E, 8'h00, 8'hFF, 16'd5}
  };

  // tick flag, byte, typed-in expectation
  localparam stim_row_t DIR_ROWS [NUM_ROWS] = '{
    '{1'b1, 8'hFF, 1'b1, '0},
    '{1'b0, 8'h00, 1'b1, '0},
    '{1'b0, 8'h10, 1'b1,
      '{1'b1, 7'd0, 8'h10, EV_NONE, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000}},
    '{1'b0, 8'h16, 1'b1,
      '{1'b1, 7'd1, 8'h16, EV_ACK, 8'h16, 8'h00, 8'h00, 16'h0026, 16'h0000}},
    '{1'b0, 8'h10, 1'b0, '0},
    '{1'b0, 8'h19, 1'b0, '0},
    '{1'b0, 8'h10, 1'b0, '0},
    '{1'b0, 8'h10, 1'b0, '0},
    '{1'b0, 8'hFF, 1'b0, '0},
    '{1'b0, 8'h10, 1'b0, '0},
    '{1'b0, 8'h42, 1'b0, '0},
    '{1'b0, 8'h03, 1'b0, '0},
    '{1'b0, 8'hFF, 1'b0, '0},
    '{1'b0, 8'h10, 1'b0, '0},
    '{1'b0, 8'h10, 1'b0, '0},
    '{1'b0, 8'h10, 1'b0, '0},
    '{1'b0, 8'h1F, 1'b0, '0},
    '{1'b0, 8'h01, 1'b0, '0},
    '{1'b0, 8'hA3, 1'b1,
      '{1'b1, 7'd9, 8'hA3, EV_FRAME_OK, 8'h42, 8'h00, 8'h03, 16'h01A3, 16'h01A3}},
    '{1'b0, 8'h10, 1'b0, '0},
    '{1'b0, 8'h19, 1'b0, '0},
    '{1'b0, 8'h10, 1'b0, '0},
    '{1'b0, 8'h1F, 1'b0, '0},
    '{1'b0, 8'h12, 1'b0, '0},
    '{1'b0, 8'h34, 1'b0, '0},
    '{1'b0, 8'h10, 1'b0, '0},
    '{1'b0, 8'h42, 1'b0, '0},
    '{1'b1, 8'h00, 1'b0, '0},
    '{1'b1, 8'h5A, 1'b1,
      '{1'b0, 7'd0, 8'h00, EV_TIMEOUT, 8'h42, 8'h00, 8'h00, 16'h0052, 16'h0000}}
  };

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_stall, func;
  logic [7:0] rx_byte;
  logic out_valid, out_stall;
  logic byte_stored;
  logic [6:0] byte_index;
  logic [7:0] byte_value;
  logic [2:0] frame_event;
  logic [7:0] command_byte, nak_error, length_byte;
  logic [15:0] computed_check, received_check;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;

  flow_t flow = FLOW_FREE;
  logic hold_trig = 1'b0;
  logic hold_on = 1'b0;
  int sent_cnt = 0;
  int bad_cnt = 0;
  res_t pending_results[$];
  res_t got, want;

  // decoder model state
  cfg_t pcfg = '{1'b0, 16'h1021, 8'h10, 8'h1F, 8'h16, 8'h19, 16'd10};
  logic open_frame = 1'b0, esc_armed = 1'b0, end_armed = 1'b0, nak_wait = 1'b0;
  logic [7:0] stored_cnt = '0;
  logic [1:0] check_cnt = '0;
  logic [15:0] run_check = '0;
  logic [7:0] cmd_hold = '0, len_hold = '0, check_hi = '0;
  logic [15:0] idle_cnt = '0;

  dle_framed_packet_receiver_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] check_mix(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] shreg, feed;
    if (!pcfg.checksum_mode) return acc + 16'(b);
    shreg = '0;
    feed = {acc[15:8] ^ b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (shreg[15] ^ feed[15]) shreg = (shreg << 1) ^ pcfg.gen_poly;
      else shreg = shreg << 1;
      feed = feed << 1;
    end
    return (acc << 8) ^ shreg;
  endfunction

  function automatic void drop_frame();
    open_frame = 1'b0;
    esc_armed = 1'b0;
    end_armed = 1'b0;
    nak_wait = 1'b0;
    stored_cnt = '0;
    check_cnt = '0;
    run_check = '0;
    cmd_hold = '0;
    len_hold = '0;
    check_hi = '0;
  endfunction

  function automatic res_t rx_decode(input logic f, input logic [7:0] c);
    res_t r;
    logic store, sum, done, is_ack, stuffed;
    logic [7:0] err;
    logic [15:0] recv;
    r = '0;
    store = 1'b0;
    sum = 1'b0;
    done = 1'b0;
    is_ack = 1'b0;
    stuffed = 1'b0;
    err = '0;
    recv = '0;
    if (f) begin
      if (idle_cnt != 0) begin
        idle_cnt = idle_cnt - 1'b1;
        if (idle_cnt == 0) begin
          if (open_frame) begin
            r.frame_event = EV_TIMEOUT;
            r.command_byte = cmd_hold;
            r.length_byte = len_hold;
            r.computed_check = run_check;
          end
          drop_frame();
        end
      end
      return r;
    end
    if (stored_cnt >= MAX_FRAME_BYTES) drop_frame();
    if (c == pcfg.escape_code && !end_armed) begin
      if (!open_frame) begin
        open_frame = 1'b1;
        stored_cnt = '0;
        esc_armed = 1'b1;
      end else if (esc_armed) begin
        stuffed = 1'b1;
      end else begin
        esc_armed = 1'b1;
      end
      store = 1'b1;
      sum = 1'b1;
    end else if (c == pcfg.end_code && esc_armed && !end_armed) begin
      store = 1'b1;
      sum = 1'b1;
      end_armed = 1'b1;
      check_cnt = '0;
    end else if (end_armed) begin
      store = 1'b1;
      if (check_cnt == 0) begin
        check_hi = c;
        check_cnt = 2'd1;
      end else begin
        recv = {check_hi, c};
        check_cnt = 2'd2;
        done = 1'b1;
      end
    end else if (nak_wait) begin
      err = c;
      store = 1'b1;
      done = 1'b1;
    end else if (open_frame) begin
      if (esc_armed && stored_cnt == 8'd1) begin
        cmd_hold = c;
        if (c == pcfg.nak_code) nak_wait = 1'b1;
        if (c == pcfg.ack_code) begin
          is_ack = 1'b1;
          done = 1'b1;
        end
      end
      store = 1'b1;
      sum = 1'b1;
    end
    if (c != pcfg.escape_code || stuffed) esc_armed = 1'b0;
    if (store) begin
      r.byte_stored = 1'b1;
      r.byte_index = stored_cnt[6:0];
      r.byte_value = c;
      if (stored_cnt == 8'd2) len_hold = c;
      stored_cnt = stored_cnt + 1'b1;
    end
    if (sum) run_check = check_mix(run_check, c);
    idle_cnt = pcfg.idle_timeout;
    if (done) begin
      if (is_ack) r.frame_event = EV_ACK;
      else if (nak_wait) r.frame_event = EV_NAK;
      else if (recv != run_check) r.frame_event = EV_CHECK_ERROR;
      else r.frame_event = EV_FRAME_OK;
      r.command_byte = cmd_hold;
      r.nak_error = err;
      r.length_byte = len_hold;
      r.computed_check = run_check;
      r.received_check = recv;
      drop_frame();
    end
    return r;
  endfunction

  function automatic string res_text(input res_t r);
    return $sformatf("st %0b idx %0d val %h ev %0d cmd %h err %h len %h chk %h rcv %h",
                     r.byte_stored, r.byte_index, r.byte_value, r.frame_event,
                     r.command_byte, r.nak_error, r.length_byte, r.computed_check,
                     r.received_check);
  endfunction

  function automatic logic [7:0] rand8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 15))
      0: return pcfg.escape_code;
      1: return pcfg.end_code;
      2: return pcfg.ack_code;
      3: return pcfg.nak_code;
      default: return rand8();
    endcase
  endfunction

  function automatic logic src_gap();
    if (flow == FLOW_SRC_GAPS) return $urandom_range(0, 99) < 70;
    if (flow == FLOW_BOTH) return $urandom_range(0, 99) < 37;
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_on) out_stall <= 1'b1;
    else if (flow == FLOW_SINK_STALLS) out_stall <= $urandom_range(0, 99) < 70;
    else if (flow == FLOW_BOTH) out_stall <= $urandom_range(0, 99) < 37;
    else out_stall <= 1'b0;
  end

  // long receiver hold-off, counted here while the sender keeps offering
  initial begin
    wait (hold_trig);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (80) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got = '{byte_stored, byte_index, byte_value, frame_event_t'(frame_event),
              command_byte, nak_error, length_byte, computed_check, received_check};
      if (pending_results.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= 10) $display("unexpected result: %s", res_text(got));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          bad_cnt++;
          if (bad_cnt <= 10) begin
            $display("result mismatch: exp %s", res_text(want));
            $display("                 got %s", res_text(got));
          end
        end
      end
    end
  end

  task automatic send_item(input logic f, input logic [7:0] b);
    while (src_gap()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(rx_decode(f, b));
    sent_cnt++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    send_item(1'b0, b);
  endtask

  task automatic put_tick();
    send_item(1'b1, rand8());
  endtask

  // escape bytes inside a frame go out doubled
  task automatic put_data(input logic [7:0] b);
    put_byte(b);
    if (b == pcfg.escape_code) put_byte(b);
  endtask

  task automatic short_ticks();
    int lim;
    lim = (pcfg.idle_timeout == 0 || pcfg.idle_timeout > 5) ? 4 : int'(pcfg.idle_timeout) - 1;
    if (lim > 0 && $urandom_range(0, 7) == 0) repeat ($urandom_range(1, lim)) put_tick();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_CHECKSUM_MODE:  pcfg.checksum_mode = val[0];
      CFG_GEN_POLY:       pcfg.gen_poly = val;
      CFG_ESCAPE_CODE:    pcfg.escape_code = val[7:0];
      CFG_END_CODE:       pcfg.end_code = val[7:0];
      CFG_ACK_CODE:       pcfg.ack_code = val[7:0];
      CFG_NAK_CODE:       pcfg.nak_code = val[7:0];
      CFG_IDLE_TIMEOUT:   pcfg.idle_timeout = val;
      default: ;
    endcase
  endtask

  task automatic load_setting(input cfg_t s);
    drain();
    cfg_write(CFG_CHECKSUM_MODE, {15'd0, s.checksum_mode});
    cfg_write(CFG_GEN_POLY, s.gen_poly);
    cfg_write(CFG_ESCAPE_CODE, {8'd0, s.escape_code});
    cfg_write(CFG_END_CODE, {8'd0, s.end_code});
    cfg_write(CFG_ACK_CODE, {8'd0, s.ack_code});
    cfg_write(CFG_NAK_CODE, {8'd0, s.nak_code});
    cfg_write(CFG_IDLE_TIMEOUT, s.idle_timeout);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame();
    int kind, n;
    logic [15:0] chk;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      put_byte(pcfg.escape_code);
      put_byte(pcfg.ack_code);
    end else if (kind < 30) begin
      put_byte(pcfg.escape_code);
      put_byte(pcfg.nak_code);
      short_ticks();
      put_byte(rand8());
    end else if (kind < 70) begin
      put_byte(pcfg.escape_code);
      put_byte(rand8());
      n = $urandom_range(0, 12);
      put_data(8'(n));
      repeat (n) begin
        put_data(pick_byte());
        short_ticks();
      end
      put_byte(pcfg.escape_code);
      put_byte(pcfg.end_code);
      chk = run_check;
      if ($urandom_range(0, 3) == 0) chk = chk ^ 16'($urandom_range(1, 65535));
      put_byte(chk[15:8]);
      put_byte(chk[7:0]);
    end else if (kind < 80) begin
      put_byte(pcfg.escape_code);
      repeat ($urandom_range(1, 4)) put_data(pick_byte());
      if (pcfg.idle_timeout != 0 && pcfg.idle_timeout <= 64)
        repeat (pcfg.idle_timeout) put_tick();
    end else if (kind < 90) begin
      repeat ($urandom_range(1, 5)) begin
        if ($urandom_range(0, 1) == 1) put_tick();
        else put_byte(rand8());
      end
    end else if (kind < 95) begin
      put_byte(pcfg.escape_code);
      put_byte(rand8());
      put_byte(pcfg.escape_code);
      put_byte(rand8());
    end else begin
      repeat ($urandom_range(1, 4)) put_tick();
    end
  endtask

  initial begin
    #5_000_000;
    $display("dle_framed_packet_receiver_top: mismatch");
    $finish;
  end

  initial begin
    cfg_t s;
    int base;
    logic long_done;
    logic [7:0] b;
    rst = 1'b1;
    in_valid = 1'b0;
    func = 1'b0;
    rx_byte = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    load_setting(DIRECTED_CFG);
    for (int i = 0; i < NUM_ROWS; i++) begin
      send_item(DIR_ROWS[i].f, DIR_ROWS[i].b);
      if (DIR_ROWS[i].typed) pending_results[pending_results.size() - 1] = DIR_ROWS[i].exp;
    end

    for (int ph = 0; ph < 7; ph++) begin
      if (ph < 6) begin
        s = PHASE_CFG[ph];
      end else begin
        s.checksum_mode = 1'($urandom_range(0, 1));
        s.gen_poly = 16'($urandom_range(0, 65535));
        s.escape_code = rand8();
        s.end_code = rand8();
        s.ack_code = rand8();
        s.nak_code = rand8();
        s.idle_timeout = 16'($urandom_range(1, 30));
      end
      load_setting(s);
      flow = flow_t'(ph % 4);
      if (ph == 4) hold_trig = 1'b1;
      base = sent_cnt;
      long_done = (ph != 1);
      while (sent_cnt - base < PHASE_ITEMS) begin
        if (!long_done && sent_cnt - base >= 60) begin
          // overlong frame: runs past the buffer limit
          put_byte(pcfg.escape_code);
          do b = rand8();
          while (b == pcfg.escape_code || b == pcfg.ack_code || b == pcfg.nak_code);
          put_byte(b);
          repeat (140) begin
            b = rand8();
            if (b == pcfg.escape_code) b = b + 1'b1;
            put_byte(b);
          end
          drain();
          long_done = 1'b1;
        end else begin
          send_frame();
        end
      end
    end

    drain();
    repeat (6) @(posedge clk);
    if (bad_cnt == 0) begin
      $display("dle_framed_packet_receiver_top: match");
    end else begin
      $display("dle_framed_packet_receiver_top: mismatch");
    end
    $finish;
  end

endmodule
